[rtl/hrsp_pkg.sv]
// Shared types, constants and character classes for the HTTP request stream parser.
package hrsp_pkg;

	localparam int LENGTH_BITS = 32;
	localparam int CL_LEN = 14;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = 1;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_HT = 8'h09;
	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_DEL = 8'd127;

	typedef enum logic [4:0] {
		PH_REQ_START, PH_METHOD, PH_URI, PH_H, PH_T1, PH_T2, PH_P, PH_SLASH,
		PH_MAJ_START, PH_MAJ, PH_MIN_START, PH_MIN, PH_NL_REQ, PH_HDR_START,
		PH_HDR_LWS, PH_HDR_NAME, PH_VAL_SPACE, PH_HDR_VALUE, PH_NL_HDR,
		PH_NL_BODY, PH_BODY, PH_FINISHED, PH_ERROR
	} phase_t;

	typedef enum logic [2:0] {
		ROLE_DELIM = 3'd0, ROLE_METHOD = 3'd1, ROLE_URI = 3'd2,
		ROLE_NAME = 3'd3, ROLE_VALUE = 3'd4, ROLE_BODY = 3'd5
	} role_t;

	typedef enum logic [2:0] {
		ST_CONT = 3'd0, ST_REQ_DONE = 3'd1, ST_HDR_DONE = 3'd2,
		ST_FINISHED = 3'd3, ST_ERROR = 3'd4
	} status_t;

	// Result of one byte as it travels from front to back.
	typedef struct packed {
		logic [2:0] byte_role;
		logic header_first;
		logic [2:0] status;
		logic [7:0] major_version;
		logic [7:0] minor_version;
		logic [31:0] body_left;
	} result_t;

	function automatic logic [7:0] cl_char(input logic [3:0] pos);
		case (pos)
			4'd0: cl_char = 8'h43; 4'd1: cl_char = 8'h6f; 4'd2: cl_char = 8'h6e;
			4'd3: cl_char = 8'h74; 4'd4: cl_char = 8'h65; 4'd5: cl_char = 8'h6e;
			4'd6: cl_char = 8'h74; 4'd7: cl_char = 8'h2d; 4'd8: cl_char = 8'h4c;
			4'd9: cl_char = 8'h65; 4'd10: cl_char = 8'h6e; 4'd11: cl_char = 8'h67;
			4'd12: cl_char = 8'h74; 4'd13: cl_char = 8'h68;
			default: cl_char = 8'h00;
		endcase
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		is_alpha = (c inside {[8'h41:8'h5a], [8'h61:8'h7a]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c inside {[8'h30:8'h39]});
	endfunction

	function automatic logic is_ctl(input logic [7:0] c);
		is_ctl = (c < 8'd32) || (c == CH_DEL);
	endfunction

	function automatic logic is_token(input logic [7:0] c);
		is_token = (c inside {[8'd33:8'd126]}) &&
			!(c inside {8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a,
			8'h5c, 8'h22, 8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d});
	endfunction

	// Saturating version digit append: v*10 + d, clipped at 255.
	function automatic logic [7:0] ver_add(input logic [7:0] v, input logic [3:0] d);
		logic [11:0] n;
		n = {4'd0, v} * 12'd10 + {8'd0, d};
		ver_add = (n > 12'd255) ? 8'hff : n[7:0];
	endfunction

endpackage

[rtl/hrsp_front.sv]
// Front end: byte classifier and parse FSM, one byte per in_valid cycle.
module hrsp_front import hrsp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [7:0] data_byte,
	output result_t res
);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
	localparam logic [LENGTH_BITS-1:0] LEN_LIM = LEN_MAX / 10;
	localparam logic [LENGTH_BITS-1:0] LEN_REM = LEN_MAX % 10;

	phase_t phase_q, phase_d;
	logic [7:0] major_q, major_d, minor_q, minor_d;
	logic have_hdr_q, have_hdr_d;
	logic [3:0] mpos_q, mpos_d;
	logic mlive_q, mlive_d;
	logic lact_q, lact_d;
	logic lseen_q, lseen_d;
	logic [LENGTH_BITS-1:0] lacc_q, lacc_d;
	logic [LENGTH_BITS-1:0] brem_q, brem_d;
	logic [2:0] role;
	logic first;
	logic [2:0] status;
	logic err;
	logic [3:0] dig;
	logic nm_hit;
	logic len_sat;
	logic [LENGTH_BITS-1:0] lacc_next;
	logic [LENGTH_BITS-1:0] brem_dec;

	assign dig = data_byte[3:0] - CH_ZERO[3:0];
	assign nm_hit = mlive_q && (mpos_q < 4'(CL_LEN)) && (data_byte == cl_char(mpos_q));
	// Saturate when acc*10+d would exceed the maximum.
	assign len_sat = (lacc_q > LEN_LIM) ||
		((lacc_q == LEN_LIM) && ({{(LENGTH_BITS-4){1'b0}}, dig} > LEN_REM));
	assign lacc_next = len_sat ? LEN_MAX :
		(lacc_q * LENGTH_BITS'(10)) + {{(LENGTH_BITS-4){1'b0}}, dig};
	assign brem_dec = (brem_q != '0) ? brem_q - 1'b1 : brem_q;

	always_comb begin
		phase_d = phase_q;
		major_d = major_q;
		minor_d = minor_q;
		have_hdr_d = have_hdr_q;
		mpos_d = mpos_q;
		mlive_d = mlive_q;
		lact_d = lact_q;
		lseen_d = lseen_q;
		lacc_d = lacc_q;
		brem_d = brem_q;
		role = ROLE_DELIM;
		first = 1'b0;
		status = ST_CONT;
		err = 1'b0;
		case (phase_q)
			PH_REQ_START: begin
				if (is_alpha(data_byte)) begin
					phase_d = PH_METHOD;
					role = ROLE_METHOD;
				end else err = 1'b1;
			end
			PH_METHOD: begin
				if (data_byte == CH_SP) phase_d = PH_URI;
				else if (is_alpha(data_byte)) role = ROLE_METHOD;
				else err = 1'b1;
			end
			PH_URI: begin
				if (data_byte == CH_SP) phase_d = PH_H;
				else if (is_ctl(data_byte)) err = 1'b1;
				else role = ROLE_URI;
			end
			PH_H: if (data_byte == CH_H) phase_d = PH_T1; else err = 1'b1;
			PH_T1: if (data_byte == CH_T) phase_d = PH_T2; else err = 1'b1;
			PH_T2: if (data_byte == CH_T) phase_d = PH_P; else err = 1'b1;
			PH_P: if (data_byte == CH_P) phase_d = PH_SLASH; else err = 1'b1;
			PH_SLASH: begin
				if (data_byte == CH_SLASH) begin
					major_d = '0;
					minor_d = '0;
					phase_d = PH_MAJ_START;
				end else err = 1'b1;
			end
			PH_MAJ_START: begin
				if (is_digit(data_byte)) begin
					major_d = ver_add(major_q, dig);
					phase_d = PH_MAJ;
				end else err = 1'b1;
			end
			PH_MAJ: begin
				if (data_byte == CH_DOT) phase_d = PH_MIN_START;
				else if (is_digit(data_byte)) major_d = ver_add(major_q, dig);
				else err = 1'b1;
			end
			PH_MIN_START: begin
				if (is_digit(data_byte)) begin
					minor_d = ver_add(minor_q, dig);
					phase_d = PH_MIN;
				end else err = 1'b1;
			end
			PH_MIN: begin
				if (data_byte == CH_CR) phase_d = PH_NL_REQ;
				else if (is_digit(data_byte)) minor_d = ver_add(minor_q, dig);
				else err = 1'b1;
			end
			PH_NL_REQ: begin
				if (data_byte == CH_LF) begin
					phase_d = PH_HDR_START;
					status = ST_REQ_DONE;
				end else err = 1'b1;
			end
			PH_HDR_START: begin
				if (data_byte == CH_CR) begin
					lact_d = 1'b0;
					phase_d = PH_NL_BODY;
				end else if (have_hdr_q && (data_byte == CH_SP || data_byte == CH_HT)) begin
					phase_d = PH_HDR_LWS;
				end else if (is_token(data_byte)) begin
					have_hdr_d = 1'b1;
					lact_d = 1'b0;
					// Fresh match against the first name character.
					if (data_byte == cl_char(4'd0)) begin
						mpos_d = 4'd1;
						mlive_d = 1'b1;
					end else begin
						mpos_d = 4'd0;
						mlive_d = 1'b0;
					end
					role = ROLE_NAME;
					first = 1'b1;
					phase_d = PH_HDR_NAME;
				end else err = 1'b1;
			end
			PH_HDR_NAME: begin
				if (data_byte == CH_COLON) begin
					if (mlive_q && mpos_q == 4'(CL_LEN) && !lseen_q) begin
						lseen_d = 1'b1;
						lact_d = 1'b1;
						lacc_d = '0;
					end
					phase_d = PH_VAL_SPACE;
				end else if (is_token(data_byte)) begin
					if (nm_hit) mpos_d = mpos_q + 4'd1;
					else mlive_d = 1'b0;
					role = ROLE_NAME;
				end else err = 1'b1;
			end
			PH_VAL_SPACE: if (data_byte == CH_SP) phase_d = PH_HDR_VALUE; else err = 1'b1;
			PH_HDR_LWS, PH_HDR_VALUE: begin
				if (data_byte == CH_CR) begin
					phase_d = PH_NL_HDR;
				end else if (phase_q == PH_HDR_LWS &&
						(data_byte == CH_SP || data_byte == CH_HT)) begin
					role = ROLE_DELIM;
				end else if (is_ctl(data_byte)) begin
					err = 1'b1;
				end else if (lact_q) begin
					if (is_digit(data_byte)) begin
						lacc_d = lacc_next;
						role = ROLE_VALUE;
						phase_d = PH_HDR_VALUE;
					end else err = 1'b1;
				end else begin
					role = ROLE_VALUE;
					phase_d = PH_HDR_VALUE;
				end
			end
			PH_NL_HDR: if (data_byte == CH_LF) phase_d = PH_HDR_START; else err = 1'b1;
			PH_NL_BODY: begin
				if (data_byte == CH_LF) begin
					if (lseen_q && lacc_q != '0) begin
						brem_d = lacc_q;
						phase_d = PH_BODY;
						status = ST_HDR_DONE;
					end else begin
						phase_d = PH_FINISHED;
						status = ST_FINISHED;
					end
				end else err = 1'b1;
			end
			PH_BODY: begin
				role = ROLE_BODY;
				brem_d = brem_dec;
				if (brem_dec == '0) begin
					phase_d = PH_FINISHED;
					status = ST_FINISHED;
				end
			end
			PH_FINISHED: status = ST_FINISHED;
			default: err = 1'b1;
		endcase
		if (err) begin
			// Sticky error: drop every other update.
			phase_d = PH_ERROR;
			major_d = major_q;
			minor_d = minor_q;
			have_hdr_d = have_hdr_q;
			mpos_d = mpos_q;
			mlive_d = mlive_q;
			lact_d = lact_q;
			lseen_d = lseen_q;
			lacc_d = lacc_q;
			brem_d = brem_q;
			role = ROLE_DELIM;
			first = 1'b0;
			status = ST_ERROR;
		end
	end

	always_comb begin
		res.byte_role = role;
		res.header_first = first;
		res.status = status;
		res.major_version = major_d;
		res.minor_version = minor_d;
		if (LENGTH_BITS > 32 && (brem_d >> 32) != '0) res.body_left = '1;
		else res.body_left = 32'(brem_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_REQ_START;
			major_q <= '0;
			minor_q <= '0;
			have_hdr_q <= 1'b0;
			mpos_q <= '0;
			mlive_q <= 1'b1;
			lact_q <= 1'b0;
			lseen_q <= 1'b0;
			lacc_q <= '0;
			brem_q <= '0;
		end else if (in_valid) begin
			phase_q <= phase_d;
			major_q <= major_d;
			minor_q <= minor_d;
			have_hdr_q <= have_hdr_d;
			mpos_q <= mpos_d;
			mlive_q <= mlive_d;
			lact_q <= lact_d;
			lseen_q <= lseen_d;
			lacc_q <= lacc_d;
			brem_q <= brem_d;
		end
	end

`ifndef ASSERT_OFF
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERROR && in_valid) |-> (res.status == ST_ERROR))
		else $error("error phase left");
	a_body_role: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY && in_valid) |-> (res.byte_role == ROLE_BODY))
		else $error("body byte not tagged");
	a_first_name: assert property (@(posedge clk) disable iff (!arst_n)
		res.header_first |-> (res.byte_role == ROLE_NAME))
		else $error("header_first without name role");
`endif

endmodule

[rtl/hrsp_queue.sv]
// Short result queue between the parse front end and the output side.
module hrsp_queue import hrsp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input result_t wr_data,
	output logic full,
	input logic rd_en,
	output logic empty,
	output result_t rd_data
);

	result_t mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wptr_q, rptr_q;
	logic [QUEUE_AW:0] count_q;

	assign full = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) wptr_q <= wptr_q + 1'b1;
			if (rd_en) rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + (QUEUE_AW+1)'(wr_en) - (QUEUE_AW+1)'(rd_en);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !rd_en) |=> (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH)))
		else $error("queue count moved while full");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
		else $error("queue count out of range");
	a_ptr_sync: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (wptr_q == rptr_q))
		else $error("pointers differ while empty");
`endif

endmodule

[rtl/http_request_stream_parser_top.sv]
// Top level of the HTTP request stream parser.
//
//  channel  | handshake       | fields
//  ---------+-----------------+-------------------------------------------------
//  input    | push / full     | data_byte
//  result   | pop / empty     | byte_role header_first status major_version
//           |                 | minor_version body_left
//
// One byte is parsed per clock while push is high and full low; the parse state
// machine in the front end sets that figure. A result is written into a
// two-entry queue when its byte is accepted and waits there, so input and
// result sides stall independently. Reset puts the parser at request start
// with an empty queue. full rises only when both entries hold untaken results.
module http_request_stream_parser_top import hrsp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] data_byte,
	input logic pop,
	output logic empty,
	output logic [2:0] byte_role,
	output logic header_first,
	output logic [2:0] status,
	output logic [7:0] major_version,
	output logic [7:0] minor_version,
	output logic [31:0] body_left
);

	logic take;
	logic give;
	result_t front_res;
	result_t back_res;

	// A transaction on each side moves exactly one byte or one result.
	assign take = push && !full;
	assign give = pop && !empty;

	hrsp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(take),
		.data_byte(data_byte),
		.res(front_res)
	);

	hrsp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(take),
		.wr_data(front_res),
		.full(full),
		.rd_en(give),
		.empty(empty),
		.rd_data(back_res)
	);

	assign byte_role = back_res.byte_role;
	assign header_first = back_res.header_first;
	assign status = back_res.status;
	assign major_version = back_res.major_version;
	assign minor_version = back_res.minor_version;
	assign body_left = back_res.body_left;

`ifndef ASSERT_OFF
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !give) |=> !empty)
		else $error("accepted byte left no result");
	a_role_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (byte_role <= ROLE_BODY))
		else $error("role code out of range");
	a_err_role: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_ERROR) |-> (byte_role == ROLE_DELIM))
		else $error("error result carries a role");
`endif

endmodule
